// ----- src/dmc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types, constants and arithmetic helpers of the matching counter.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam logic [29:0] MODP          = 30'd1000000007;
  localparam logic [3:0]  VCOUNT_RESET  = 4'd10;
  localparam int          OPW           = 30;  // modular operand width
  localparam int          CW            = 4;   // digit step counter width

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_DP_INIT,
    ST_SUBSET,
    ST_PAIR_RD,
    ST_PAIR_LOAD,
    ST_PAIR_MUL,
    ST_SUBSET_WR,
    ST_OUT_LOAD,
    ST_OUT_MUL
  } state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] vertex_a;
    logic [3:0] vertex_b;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  match_size;
    logic [29:0] match_count;
    logic        last;
  } out_word_t;

  // slot of unordered pair lo < hi
  function automatic logic [6:0] pair_slot(input logic [3:0] lo, input logic [3:0] hi);
    logic [7:0] tri_n;
    tri_n = (8'(hi) * 8'(hi - 4'd1)) >> 1;
    return 7'(tri_n + 8'(lo));
  endfunction

  // inverse of k! mod P
  function automatic logic [29:0] inv_fact(input logic [2:0] k);
    logic [29:0] r;
    case (k)
      3'd2:    r = 30'd500000004;
      3'd3:    r = 30'd166666668;
      3'd4:    r = 30'd41666667;
      3'd5:    r = 30'd808333339;
      3'd6:    r = 30'd301388891;
      default: r = 30'd1;
    endcase
    return r;
  endfunction

  // (a + b) mod P, both below P
  function automatic logic [29:0] add_mod(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] s;
    s = 31'(a) + 31'(b);
    if (s >= 31'(MODP)) s = s - 31'(MODP);
    return s[29:0];
  endfunction

  // x mod P for x below 7P
  function automatic logic [29:0] reduce7(input logic [32:0] x);
    logic [32:0] p1;
    logic [32:0] r;
    p1 = 33'(MODP);
    if      (x >= 33'd6 * p1) r = x - 33'd6 * p1;
    else if (x >= 33'd5 * p1) r = x - 33'd5 * p1;
    else if (x >= 33'd4 * p1) r = x - 33'd4 * p1;
    else if (x >= 33'd3 * p1) r = x - 33'd3 * p1;
    else if (x >= 33'd2 * p1) r = x - 33'd2 * p1;
    else if (x >= p1)         r = x - p1;
    else                      r = x;
    return r[29:0];
  endfunction

endpackage

// ----- src/dmc_ram.sv -----
// ----------------------------------------------------------------------------
// dmc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/dynamic_matching_counter.sv -----
// ----------------------------------------------------------------------------
// dynamic_matching_counter
// Edge multiplicity table plus subset DP counting k-edge matchings mod 1e9+7.
// ----------------------------------------------------------------------------
//
//  channel   | signals                   | handshake
//  ----------+---------------------------+----------------------------------
//  command   | start, busy, in_word_i    | word taken when start & !busy
//  result    | strobe_o, out_word_o      | one-cycle strobe per word, no back-pressure
//  config    | cfg_we_i, cfg_data_i      | vertex_count written when cfg_we_i
//
//  Clear and unused kind: done in the accepting cycle, no words out.
//  Add/remove: a table update when the edge is well formed, then a pass over
//  each subset of the active n vertices plus, per even subset, a read, load
//  and digit-serial multiply for each vertex pair in it (C(n,2)*2^(n-3)
//  pairs in all, n > 2) through the single radix-4 multiply-modulo unit and a
//  write-back; then a load and a multiply for each result word.
//  Reset clears the table valid bits and sets vertex_count to 10; results
//  cannot be stalled, busy holds off commands for the whole update.
//
module dynamic_matching_counter #(
  parameter int MAX_VERTICES = 10,
  parameter int MULT_WIDTH   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  dmc_pkg::in_word_t   in_word_i,
  output logic                strobe_o,
  output dmc_pkg::out_word_t  out_word_o,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_data_i
);

  import dmc_pkg::*;

  localparam int PAIRS     = (MAX_VERTICES * (MAX_VERTICES - 1)) / 2;
  localparam int SLOT_W    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int SUBSETS   = 1 << MAX_VERTICES;
  localparam int SW        = MAX_VERTICES + 1;
  localparam int JW        = $clog2(MAX_VERTICES);
  localparam int TOT_DEPTH = MAX_VERTICES / 2 + 1;
  localparam int TW        = (TOT_DEPTH > 1) ? $clog2(TOT_DEPTH) : 1;
  localparam int MDW       = 2 * ((MULT_WIDTH + 1) / 2);
  localparam logic [MULT_WIDTH-1:0] MULT_MAX = '1;

  // lowest set bit of a vertex mask
  function automatic logic [JW-1:0] lowest(input logic [MAX_VERTICES-1:0] m);
    logic [JW-1:0] r;
    r = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (m[i]) r = JW'(i);
    end
    return r;
  endfunction

  function automatic logic [3:0] popcnt(input logic [MAX_VERTICES-1:0] m);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      c = c + 4'(m[i]);
    end
    return c;
  endfunction

  state_e                  state_q, state_d;
  logic [3:0]              vcount_q, vcount_d;
  logic [PAIRS-1:0]        ev_valid_q, ev_valid_d;
  logic                    strobe_q, strobe_d;

  kind_e                   kind_q, kind_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic                    ev_hit_q, ev_hit_d;
  logic [3:0]              n_q, n_d;
  logic [SW-1:0]           s_q, s_d;
  logic [JW-1:0]           j_q, j_d;
  logic [MAX_VERTICES-1:0] jrem_q, jrem_d;
  logic [MAX_VERTICES-1:0] mrem_q, mrem_d;
  logic [29:0]             acc_q, acc_d;
  logic [29:0]             tot_q [TOT_DEPTH];
  logic [29:0]             tot_d [TOT_DEPTH];
  logic [2:0]              k_q, k_d;
  logic [29:0]             mul_a_q, mul_a_d;
  logic [OPW-1:0]          mul_b_q, mul_b_d;
  logic [29:0]             mul_p_q, mul_p_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  out_word_t               out_q, out_d;

  // memory ports
  logic                    em_we;
  logic [SLOT_W-1:0]       em_waddr, em_raddr;
  logic [MULT_WIDTH-1:0]   em_wdata, em_rdata;
  logic                    ways_we;
  logic [MAX_VERTICES-1:0] ways_waddr, ways_raddr;
  logic [29:0]             ways_wdata, ways_rdata;

  dmc_ram #(.WIDTH(MULT_WIDTH), .DEPTH(PAIRS), .AW(SLOT_W)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (em_we),
    .waddr_i (em_waddr),
    .wdata_i (em_wdata),
    .raddr_i (em_raddr),
    .rdata_o (em_rdata)
  );

  dmc_ram #(.WIDTH(30), .DEPTH(SUBSETS), .AW(MAX_VERTICES)) u_ways_ram (
    .clk_i   (clk_i),
    .we_i    (ways_we),
    .waddr_i (ways_waddr),
    .wdata_i (ways_wdata),
    .raddr_i (ways_raddr),
    .rdata_o (ways_rdata)
  );

  // command decode
  logic                    edge_ok;
  logic [3:0]              e_lo, e_hi;
  logic [SLOT_W-1:0]       in_slot;

  assign edge_ok = (in_word_i.vertex_a != in_word_i.vertex_b) &&
                   (in_word_i.vertex_a < 4'(MAX_VERTICES)) &&
                   (in_word_i.vertex_b < 4'(MAX_VERTICES));
  assign e_lo    = (in_word_i.vertex_a < in_word_i.vertex_b) ? in_word_i.vertex_a
                                                              : in_word_i.vertex_b;
  assign e_hi    = (in_word_i.vertex_a < in_word_i.vertex_b) ? in_word_i.vertex_b
                                                              : in_word_i.vertex_a;
  always_comb begin
    logic [6:0] sl;
    sl      = pair_slot(e_lo, e_hi);
    in_slot = sl[SLOT_W-1:0];
  end

  // subset bookkeeping
  logic [3:0]              pc;
  logic [SW-1:0]           full;
  logic [TW-1:0]           tot_idx;
  logic [2:0]              half;

  assign pc      = popcnt(s_q[MAX_VERTICES-1:0]);
  assign full    = SW'(1) << n_q;
  assign tot_idx = TW'(pc >> 1);
  assign half    = 3'(n_q >> 1);

  // radix-4 multiply-modulo step: p <- (4p + a*digit) mod P
  logic [1:0]              mdig;
  logic [32:0]             mad;
  logic [29:0]             mul_p_next;

  always_comb begin
    mdig = mul_b_q[OPW-1 -: 2];
    case (mdig)
      2'd1:    mad = 33'(mul_a_q);
      2'd2:    mad = 33'(mul_a_q) << 1;
      2'd3:    mad = 33'(mul_a_q) + (33'(mul_a_q) << 1);
      default: mad = '0;
    endcase
    mul_p_next = reduce7((33'(mul_p_q) << 2) + mad);
  end

  // pair selection
  logic [JW-1:0]           m_idx;
  logic [JW-1:0]           nj_idx;
  logic [MAX_VERTICES-1:0] nj_rem;
  logic [SLOT_W-1:0]       pair_sl;

  assign m_idx  = lowest(mrem_q);
  assign nj_idx = lowest(jrem_q);
  assign nj_rem = jrem_q & ~(MAX_VERTICES'(1) << nj_idx);

  always_comb begin
    logic [6:0] sl;
    sl      = pair_slot(4'(j_q), 4'(m_idx));
    pair_sl = sl[SLOT_W-1:0];
  end

  always_comb begin
    logic [MULT_WIDTH-1:0]   cur;
    logic [MULT_WIDTH-1:0]   mult_g;
    logic [MAX_VERTICES-1:0] s_lo;
    logic [JW-1:0]           j0;

    state_d    = state_q;
    vcount_d   = vcount_q;
    ev_valid_d = ev_valid_q;
    strobe_d   = 1'b0;
    kind_d     = kind_q;
    slot_d     = slot_q;
    ev_hit_d   = ev_hit_q;
    n_d        = n_q;
    s_d        = s_q;
    j_d        = j_q;
    jrem_d     = jrem_q;
    mrem_d     = mrem_q;
    acc_d      = acc_q;
    tot_d      = tot_q;
    k_d        = k_q;
    mul_a_d    = mul_a_q;
    mul_b_d    = mul_b_q;
    mul_p_d    = mul_p_q;
    cnt_d      = cnt_q;
    out_d      = out_q;

    em_we      = 1'b0;
    em_waddr   = slot_q;
    em_wdata   = '0;
    em_raddr   = in_slot;
    ways_we    = 1'b0;
    ways_waddr = s_q[MAX_VERTICES-1:0];
    ways_wdata = acc_q;
    ways_raddr = '0;

    s_lo   = s_q[MAX_VERTICES-1:0];
    j0     = lowest(s_lo);
    cur    = ev_hit_q ? em_rdata : '0;
    mult_g = ev_hit_q ? em_rdata : '0;

    if (cfg_we_i) begin
      vcount_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          kind_d = kind_e'(in_word_i.kind);
          case (kind_e'(in_word_i.kind))
            KIND_CLEAR: ev_valid_d = '0;
            KIND_ADD, KIND_REMOVE: begin
              if (edge_ok) begin
                slot_d   = in_slot;
                ev_hit_d = ev_valid_q[in_slot];
                state_d  = ST_EDGE_WR;
              end else begin
                state_d  = ST_DP_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EDGE_WR: begin
        em_we = 1'b1;
        if (kind_q == KIND_ADD) begin
          em_wdata = (cur == MULT_MAX) ? cur : cur + 1'b1;
        end else begin
          em_wdata = (cur == '0) ? cur : cur - 1'b1;
        end
        ev_valid_d[slot_q] = 1'b1;
        state_d = ST_DP_INIT;
      end
      ST_DP_INIT: begin
        if (vcount_q < 4'd2) begin
          n_d = 4'd2;
        end else if (vcount_q > 4'(MAX_VERTICES)) begin
          n_d = 4'(MAX_VERTICES);
        end else begin
          n_d = vcount_q;
        end
        ways_we    = 1'b1;
        ways_waddr = '0;
        ways_wdata = 30'd1;
        for (int i = 0; i < TOT_DEPTH; i++) begin
          tot_d[i] = '0;
        end
        s_d     = SW'(1);
        state_d = ST_SUBSET;
      end
      ST_SUBSET: begin
        if (s_q == full) begin
          k_d     = 3'd1;
          state_d = ST_OUT_LOAD;
        end else if (pc[0]) begin
          s_d = s_q + 1'b1;
        end else begin
          j_d     = j0;
          jrem_d  = s_lo & ~(MAX_VERTICES'(1) << j0);
          mrem_d  = s_lo & ~(MAX_VERTICES'(1) << j0);
          acc_d   = '0;
          state_d = ST_PAIR_RD;
        end
      end
      ST_PAIR_RD: begin
        mrem_d     = mrem_q & ~(MAX_VERTICES'(1) << m_idx);
        ways_raddr = s_lo & ~((MAX_VERTICES'(1) << j_q) | (MAX_VERTICES'(1) << m_idx));
        em_raddr   = pair_sl;
        ev_hit_d   = ev_valid_q[pair_sl];
        state_d    = ST_PAIR_LOAD;
      end
      ST_PAIR_LOAD: begin
        mul_a_d = ways_rdata;
        mul_b_d = OPW'(mult_g) << (OPW - MDW);
        mul_p_d = '0;
        cnt_d   = CW'(MDW / 2);
        state_d = ST_PAIR_MUL;
      end
      ST_PAIR_MUL: begin
        mul_p_d = mul_p_next;
        mul_b_d = mul_b_q << 2;
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          acc_d = add_mod(acc_q, mul_p_next);
          if (mrem_q != '0) begin
            state_d = ST_PAIR_RD;
          end else if (nj_rem != '0) begin
            j_d     = nj_idx;
            jrem_d  = nj_rem;
            mrem_d  = nj_rem;
            state_d = ST_PAIR_RD;
          end else begin
            state_d = ST_SUBSET_WR;
          end
        end
      end
      ST_SUBSET_WR: begin
        ways_we        = 1'b1;
        tot_d[tot_idx] = add_mod(tot_q[tot_idx], acc_q);
        s_d            = s_q + 1'b1;
        state_d        = ST_SUBSET;
      end
      ST_OUT_LOAD: begin
        mul_a_d = tot_q[TW'(k_q)];
        mul_b_d = inv_fact(k_q);
        mul_p_d = '0;
        cnt_d   = CW'(OPW / 2);
        state_d = ST_OUT_MUL;
      end
      ST_OUT_MUL: begin
        mul_p_d = mul_p_next;
        mul_b_d = mul_b_q << 2;
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          strobe_d          = 1'b1;
          out_d.match_size  = k_q;
          out_d.match_count = mul_p_next;
          out_d.last        = (k_q == half);
          if (k_q == half) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_OUT_LOAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      vcount_q   <= VCOUNT_RESET;
      ev_valid_q <= '0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      vcount_q   <= vcount_d;
      ev_valid_q <= ev_valid_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    slot_q   <= slot_d;
    ev_hit_q <= ev_hit_d;
    n_q      <= n_d;
    s_q      <= s_d;
    j_q      <= j_d;
    jrem_q   <= jrem_d;
    mrem_q   <= mrem_d;
    acc_q    <= acc_d;
    tot_q    <= tot_d;
    k_q      <= k_d;
    mul_a_q  <= mul_a_d;
    mul_b_q  <= mul_b_d;
    mul_p_q  <= mul_p_d;
    cnt_q    <= cnt_d;
    out_q    <= out_d;
  end

  assign busy       = (state_q != ST_IDLE);
  assign strobe_o   = strobe_q;
  assign out_word_o = out_q;

endmodule

// ----- dv/dynamic_matching_counter_tb.sv -----
// ----------------------------------------------------------------------------
// dynamic_matching_counter_tb
// Drives add, remove and clear commands into the matching counter under
// several vertex counts. A behavioural copy of the subset DP predicts every
// result word, and each strobed word is checked field by field against it.
// ----------------------------------------------------------------------------
module dynamic_matching_counter_tb;
  import dmc_pkg::*;

  localparam int  NV        = 10;          // MAX_VERTICES of the instance
  localparam int  NPAIRS    = NV * (NV - 1) / 2;
  localparam int  MULT_MAX  = 65535;       // 2^MULT_WIDTH - 1
  localparam longint P      = 64'd1000000007;
  localparam int  CYCLE_CAP = 4000000;
  localparam int  EXP_DEPTH = 16;          // outstanding predicted words
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_word_t   in_word;
  logic       strobe;
  out_word_t  out_word;
  logic       cfg_we;
  logic [3:0] cfg_data;

  // predictor state
  int        mult_tab [NPAIRS];
  int        vcount;
  longint    ways [1024];
  out_word_t exp_mem [EXP_DEPTH];
  int        exp_wr;
  int        exp_rd;

  int errors;
  int cycles;
  int idle_pct;   // chance of a gap before each command

  // inverse factorials mod P, k = 0..5
  longint inv_k [6] = '{1, 1, 500000004, 166666668, 41666667, 808333339};

  dynamic_matching_counter #(.MAX_VERTICES(NV), .MULT_WIDTH(16)) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word_i  (in_word),
    .strobe_o   (strobe),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: update the table, then, for add and remove, recount matchings of every size
  // --------------------------------------------------------------------------
  function automatic int slot_of(int lo, int hi);
    return hi * (hi - 1) / 2 + lo;
  endfunction

  function automatic void predict_counts(in_word_t w);
    int        n, half, lo, hi, pc;
    longint    acc;
    longint    totals [6];
    out_word_t r;
    if (w.kind == KIND_CLEAR) begin
      foreach (mult_tab[i]) mult_tab[i] = 0;
      return;
    end
    if (w.kind == KIND_UNUSED) return;
    // self loops and out-of-range endpoints leave the table alone
    if (w.vertex_a != w.vertex_b && w.vertex_a < NV && w.vertex_b < NV) begin
      lo = (w.vertex_a < w.vertex_b) ? w.vertex_a : w.vertex_b;
      hi = (w.vertex_a < w.vertex_b) ? w.vertex_b : w.vertex_a;
      if (w.kind == KIND_ADD) begin
        if (mult_tab[slot_of(lo, hi)] < MULT_MAX) mult_tab[slot_of(lo, hi)]++;
      end else begin
        if (mult_tab[slot_of(lo, hi)] > 0) mult_tab[slot_of(lo, hi)]--;
      end
    end
    n = (vcount < 2) ? 2 : (vcount > NV) ? NV : vcount;
    half = n / 2;
    foreach (totals[k]) totals[k] = 0;
    ways[0] = 1;
    for (int s = 1; s < (1 << n); s++) begin
      pc = $countones(s);
      acc = 0;
      if (pc % 2 == 0) begin
        for (int j = 0; j < n; j++) begin
          if (!s[j]) continue;
          for (int m = j + 1; m < n; m++) begin
            if (!s[m]) continue;
            acc = (acc + (ways[s & ~((1 << j) | (1 << m))] *
                          longint'(mult_tab[slot_of(j, m)])) % P) % P;
          end
        end
        totals[pc / 2] = (totals[pc / 2] + acc) % P;
      end
      ways[s] = acc;
    end
    for (int k = 1; k <= half; k++) begin
      r.match_size  = 3'(k);
      r.match_count = 30'((totals[k] * inv_k[k]) % P);
      r.last        = (k == half);
      exp_mem[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checker: every strobed word against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && strobe) begin
      if (exp_wr == exp_rd) begin
        report_mismatch("unexpected word, size", out_word.match_size, 0);
      end else begin
        want = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_word.match_size != want.match_size)
          report_mismatch("match_size", out_word.match_size, want.match_size);
        if (out_word.match_count != want.match_count)
          report_mismatch("match_count", out_word.match_count, want.match_count);
        if (out_word.last != want.last)
          report_mismatch("last", out_word.last, want.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driving helpers
  // --------------------------------------------------------------------------
  // Start stays high after acceptance; a drain, or a gap taken by the next call, lowers it.
  task automatic send_word(logic [1:0] kind, logic [3:0] va, logic [3:0] vb);
    in_word_t w;
    w.kind = kind;
    w.vertex_a = va;
    w.vertex_b = vb;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    predict_counts(w);
  endtask

  // Wait for every predicted word and an idle block
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_vcount(logic [3:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    vcount = v;
  endtask

  // Mostly well-formed edges inside the active range, some noise
  task automatic send_random(int n);
    int r;
    r = $urandom_range(99);
    if (r < 4)       send_word(KIND_CLEAR, 4'($urandom), 4'($urandom));
    else if (r < 7)  send_word(KIND_UNUSED, 4'($urandom), 4'($urandom));
    else if (r < 17) send_word(2'($urandom_range(1)), 4'($urandom), 4'($urandom));
    else if (r < 65) send_word(KIND_ADD, 4'($urandom_range(n - 1)),
                               4'($urandom_range(n - 1)));
    else             send_word(KIND_REMOVE, 4'($urandom_range(n - 1)),
                               4'($urandom_range(n - 1)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset value of vertex_count is the full ten vertices
  task automatic test_reset_vcount;
    send_word(KIND_ADD, 4'd0, 4'd9);
    send_word(KIND_ADD, 4'd4, 4'd5);
  endtask

  // Each command kind and corner of the edge fields on four vertices
  task automatic test_edge_cases;
    write_vcount(4'd4);
    send_word(KIND_ADD, 4'd0, 4'd1);
    send_word(KIND_ADD, 4'd3, 4'd2);
    send_word(KIND_ADD, 4'd1, 4'd0);       // multi-edge
    send_word(KIND_ADD, 4'd1, 4'd2);
    send_word(KIND_REMOVE, 4'd2, 4'd1);
    send_word(KIND_REMOVE, 4'd0, 4'd3);    // remove at zero stays zero
    send_word(KIND_ADD, 4'd2, 4'd2);       // self loop
    send_word(KIND_ADD, 4'd0, 4'd12);      // endpoint beyond the table
    send_word(KIND_REMOVE, 4'd15, 4'd15);
    send_word(KIND_ADD, 4'd15, 4'd3);
    send_word(KIND_ADD, 4'd7, 4'd8);       // stored, outside active set
    send_word(KIND_UNUSED, 4'd0, 4'd1);    // ignored
    send_word(KIND_CLEAR, 4'd9, 4'd6);
    send_word(KIND_ADD, 4'd0, 4'd2);
  endtask

  // Register extremes: below 2 acts as 2, above 10 acts as 10
  task automatic test_vcount_extremes;
    write_vcount(4'd0);
    send_word(KIND_ADD, 4'd0, 4'd1);
    write_vcount(4'd1);
    send_word(KIND_REMOVE, 4'd0, 4'd1);
    write_vcount(4'd9);
    send_word(KIND_ADD, 4'd7, 4'd8);       // pair outside the earlier active set, now inside it
    write_vcount(4'd15);
    send_word(KIND_ADD, 4'd8, 4'd9);
  endtask

  task automatic test_random_phase(int pct, int items);
    int n;
    idle_pct = pct;
    for (int i = 0; i < items; i++) begin
      if (i % 11 == 0) begin
        n = ($urandom_range(9) == 0) ? 8 : $urandom_range(2, 7);
        write_vcount(4'(n));
      end
      send_random(n);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_word  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    errors   = 0;
    cycles   = 0;
    exp_wr   = 0;
    exp_rd   = 0;
    idle_pct = 26;
    vcount   = 10;
    foreach (mult_tab[i]) mult_tab[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_vcount();
    test_edge_cases();
    test_vcount_extremes();
    test_random_phase(26, 34);
    test_random_phase(87, 34);
    test_random_phase(0, 34);
    drain();
    repeat (100) @(posedge clk);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/dmc_pkg.sv
src/dmc_ram.sv
src/dynamic_matching_counter.sv
dv/dynamic_matching_counter_tb.sv
